### rtl/pgm_pkg.sv
// Shared constants and types for the pixel gradient magnitude unit.
package pgm_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LW_W   = 11;
    localparam int FH_W   = 13;
    localparam int SUM_W  = 15;
    localparam int ROOT_W = 8;

    // Configuration register indexes
    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [ROOT_W-1:0] t_root;

endpackage

### rtl/pixel_gradient_magnitude_unit.sv
// Top level of the pixel gradient magnitude unit.
//
// Pixels enter in raster order on the slave stream (one 8-bit pixel per item)
// and each gives one result item on the master stream: the horizontal and
// vertical backward half-differences and the rounded gradient magnitude.
// The configuration channel writes line_width (index 0) and frame_height
// (index 1); it is always ready and is meant to be written between items.
// A pixel passes the line store read, the squaring stage and the bit-serial
// square-root unit (eight trial steps and a rounding step) in turn; the next
// pixel is not accepted until the result of the last one has been produced.
// The previous row lives in a 1024 x 8 line store that is read, then written
// back with the new pixel, at the current column.
// Reset clears the counters, the left pixel and the output valid, and loads
// the width 1024 and height 4096; the line store is not cleared.
// If the receiver stalls, the result waits in the output register; one more
// pixel may be processed and its result held internally until it drains.
module pixel_gradient_magnitude_unit
    import pgm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave stream: tdata = pixel[7:0]
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,
    // master stream: tdata = grad_x[7:0], grad_y[15:8], magnitude[23:16]
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [FH_W-1:0]    i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_ROOT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [LW_W-1:0]  r_line_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pix             r_left;
    t_pix             r_pix;
    logic signed [7:0] r_gx, r_gy;
    logic             r_pend;
    t_root            r_mag;
    logic             r_out_valid;
    logic [23:0]      r_out_data;

    logic             accept;
    logic             out_free;
    t_pix             above;
    logic [LW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [LW_W-1:0]  col_next;
    logic [FH_W-1:0]  row_next;
    logic signed [8:0] dx, dy, dx_adj, dy_adj;
    logic signed [7:0] gx, gy;
    logic [6:0]       ax, ay;
    t_sum             sum;
    logic             sq_done;
    t_root            sq_root;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_pend;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_W'(MAX_WIDTH);
            r_frame_height <= FH_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // effective geometry, clamped to 1..max
    always_comb begin
        if (r_line_width == '0)
            w_eff = LW_W'(1);
        else if (r_line_width > LW_W'(MAX_WIDTH))
            w_eff = LW_W'(MAX_WIDTH);
        else
            w_eff = r_line_width;
        if (r_frame_height == '0)
            h_eff = FH_W'(1);
        else if (r_frame_height > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = r_frame_height;
        col_next = {1'b0, r_col} + LW_W'(1);
        row_next = {1'b0, r_row} + FH_W'(1);
    end

    // line store: read at acceptance, written back once the old value is in
    pgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_col),
        .i_wr_data (r_pix),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (above)
    );

    // half-differences truncated toward zero
    always_comb begin
        dx     = $signed({1'b0, r_pix}) - $signed({1'b0, r_left});
        dy     = $signed({1'b0, r_pix}) - $signed({1'b0, above});
        dx_adj = dx + $signed({8'b0, dx[8]});
        dy_adj = dy + $signed({8'b0, dy[8]});
        gx     = (r_col == '0) ? 8'sd0 : dx_adj[8:1];
        gy     = (r_row == '0) ? 8'sd0 : dy_adj[8:1];
    end

    // sum of squares from the magnitudes
    always_comb begin
        ax  = r_gx[7] ? 7'(-r_gx) : r_gx[6:0];
        ay  = r_gy[7] ? 7'(-r_gy) : r_gy[6:0];
        sum = SUM_W'(ax * ax) + SUM_W'(ay * ay);
    end

    pgm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SUM),
        .i_sum   (sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: if (sq_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_left <= r_pix;
                if (col_next >= w_eff) begin
                    r_col <= '0;
                    r_row <= (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
                end else begin
                    r_col <= col_next[COL_W-1:0];
                end
            end
            // output register and the held result behind it
            if (r_state == S_ROOT && sq_done && !out_free) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if ((r_state == S_ROOT && sq_done) || r_pend) begin
                if (out_free) r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_s_axis_tdata;
        end
        if (r_state == S_READ) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (r_state == S_ROOT && sq_done) begin
            r_mag <= sq_root;
        end
        if (r_state == S_ROOT && sq_done && out_free) begin
            r_out_data <= {sq_root, r_gy, r_gx};
        end else if (r_pend && out_free) begin
            r_out_data <= {r_mag, r_gy, r_gx};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### rtl/pgm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pgm_isqrt.sv
// Bit-serial integer square root with round-to-nearest on the final step.
module pgm_isqrt
    import pgm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_sum  i_sum,
    output logic  o_done,
    output t_root o_root
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TRIAL = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;

    logic [1:0]        r_state, n_state;
    t_sum              r_sum;
    t_root             r_root, n_root;
    t_root             r_bit, n_bit;
    t_root             trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [2*ROOT_W-1:0] root_sq;
    logic [2*ROOT_W:0]   floor_lim;

    // one trial bit per cycle, most significant first
    always_comb begin
        trial     = r_root | r_bit;
        trial_sq  = trial * trial;
        root_sq   = r_root * r_root;
        floor_lim = {1'b0, root_sq} + {{(ROOT_W+1){1'b0}}, r_root};
        n_state   = r_state;
        n_root    = r_root;
        n_bit     = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_TRIAL;
                    n_root  = '0;
                    n_bit   = t_root'(1) << (ROOT_W-1);
                end
            end
            S_TRIAL: begin
                if (trial_sq <= {1'b0, r_sum}) begin
                    n_root = trial;
                end
                n_bit = r_bit >> 1;
                if (r_bit[0]) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_sum <= i_sum;
        end
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    // round up when the sum lies past root*(root+1)
    assign o_done = (r_state == S_ROUND);
    assign o_root = ({2'b0, r_sum} > floor_lim) ? r_root + t_root'(1) : r_root;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the pixel gradient magnitude unit.
module tb_top
    import pgm_pkg::*;
();

    localparam int CYCLE_LIMIT  = 300_000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_RUNS  = 12;
    localparam int RUN_ITEMS    = 60;

    // One result item, laid out as on the master stream (grad_x in the low byte)
    typedef struct packed {
        t_root             magnitude;
        logic signed [7:0] grad_y;
        logic signed [7:0] grad_x;
    } t_gradient;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [7:0]      i_s_axis_tdata;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [23:0]     o_m_axis_tdata;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic            i_cfg_index;
    logic [FH_W-1:0] i_cfg_data;

    // Predicted block state
    t_pix            line_above [MAX_WIDTH];
    t_pix            left_pix;
    int unsigned     col_pos;
    int unsigned     row_pos;
    logic [LW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;

    t_gradient       expected_grads [$];
    int              error_count;
    int unsigned     cycle_count = 0;
    int unsigned     stall_left;
    bit              no_idle;

    pixel_gradient_magnitude_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero counts as one, anything above the maximum counts as the maximum
    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Expected result for one accepted pixel; advances the predicted state
    function automatic t_gradient gradient_of(t_pix pix);
        int unsigned w, h, col, sum, root;
        int          dx, dy;
        t_gradient   g;
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        col = col_pos % MAX_WIDTH;
        // signed int division truncates toward zero
        dx  = (col != 0) ? (int'(pix) - int'(left_pix)) / 2 : 0;
        dy  = (row_pos != 0) ? (int'(pix) - int'(line_above[col])) / 2 : 0;
        sum = dx * dx + dy * dy;
        // floor root, then round to nearest (an exact .5 cannot occur)
        root = 0;
        while ((root + 1) * (root + 1) <= sum) root++;
        if (sum > root * root + root) root++;
        line_above[col] = pix;
        left_pix        = pix;
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col + 1;
        end
        g.grad_x    = dx[7:0];
        g.grad_y    = dy[7:0];
        g.magnitude = root[7:0];
        return g;
    endfunction

    // Mix of extremes, noise and small steps from the left or upper neighbor
    function automatic t_pix random_pixel();
        int base;
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return 8'($urandom);
            4, 5: base = left_pix;
            default: base = line_above[col_pos % MAX_WIDTH];
        endcase
        base += int'($urandom_range(0, 8)) - 4;
        return (base < 0) ? 8'd0 : (base > 255) ? 8'd255 : 8'(base);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (error_count < 50)
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
        error_count++;
    endtask

    // Send one pixel item, with an optional idle burst in front
    task automatic send_pixel(input t_pix pix);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_grads.push_back(gradient_of(pix));
    endtask

    task automatic write_register(input logic idx, input logic [FH_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LINE_WIDTH)
            width_reg = value[LW_W-1:0];
        else
            height_reg = value;
        @(posedge i_clk);
    endtask

    // Every pixel gives one result, so an empty queue means the block is idle
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_grads.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_setting(input logic [FH_W-1:0] w, input logic [FH_W-1:0] h,
                               input int n);
        wait_idle();
        write_register(CFG_LINE_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
        repeat (n) send_pixel(random_pixel());
    endtask

    // Reset geometry: one full row at the reset width fills the whole line
    // store, so later width changes never read an entry that was never written
    task automatic test_reset_geometry();
        repeat (MAX_WIDTH + 24) send_pixel(8'($urandom));
    endtask

    // Full-scale steps in both directions, truncation of odd differences,
    // row wrap and a new frame starting with a zero vertical difference
    task automatic test_directed_extremes();
        t_pix pattern [24];
        pattern = '{8'd0,   8'd255, 8'd0,   8'd255,
                    8'd255, 8'd0,   8'd255, 8'd0,
                    8'd1,   8'd2,   8'd3,   8'd4,
                    8'd128, 8'd127, 8'd129, 8'd126,
                    8'd3,   8'd0,   8'd5,   8'd250,
                    8'd255, 8'd255, 8'd0,   8'd0};
        wait_idle();
        write_register(CFG_LINE_WIDTH, 13'd4);
        write_register(CFG_FRAME_HEIGHT, 13'd3);
        // counters survive the write: finish the frame in progress first
        while (col_pos != 0 || row_pos != 0) send_pixel(8'($urandom));
        foreach (pattern[k]) send_pixel(pattern[k]);
    endtask

    // Out-of-range and boundary register values
    task automatic test_register_limits();
        run_setting(13'd0, 13'd0, 20);
        run_setting(13'd1, 13'd5, 24);
        run_setting(13'd7, 13'd1, 30);
        // above the maximum: width and height clamp to their limits
        run_setting(13'h7FF, 13'h1FFF, 40);
        run_setting(13'd1, 13'h1FFF, 40);
    endtask

    // Random geometries, mostly small so rows and frames wrap often;
    // width writes carry junk in the bits above the register
    task automatic test_random_settings();
        logic [FH_W-1:0] w, h;
        repeat (RANDOM_RUNS) begin
            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = FH_W'($urandom_range(13, 2047));
                default: w = FH_W'($urandom_range(1, 12));
            endcase
            w[FH_W-1:LW_W] = 2'($urandom);
            case ($urandom_range(0, 9))
                0: h = '0;
                1: h = FH_W'($urandom_range(7, 8191));
                default: h = FH_W'($urandom_range(1, 6));
            endcase
            run_setting(w, h, RUN_ITEMS);
        end
    endtask

    // Back-to-back items with no idling on either side
    task automatic test_steady_stream();
        no_idle = 1'b1;
        repeat (RUN_ITEMS) send_pixel(random_pixel());
    endtask

    // Result checker and receiver back-pressure
    always @(posedge i_clk) begin
        t_gradient got, want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_grads.size() == 0) begin
                if (error_count < 50)
                    $display("%0t: result with none expected: expected none actual %h",
                             $time, o_m_axis_tdata);
                error_count++;
            end else begin
                want = expected_grads.pop_front();
                if (got.grad_x !== want.grad_x)
                    report_mismatch("grad_x", want.grad_x, got.grad_x);
                if (got.grad_y !== want.grad_y)
                    report_mismatch("grad_y", want.grad_y, got.grad_y);
                if (got.magnitude !== want.magnitude)
                    report_mismatch("magnitude", want.magnitude, got.magnitude);
            end
        end
        if (stall_left == 0 && !no_idle && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left != 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_LINE_WIDTH;
        i_cfg_data      <= '0;
        width_reg   = LW_W'(MAX_WIDTH);
        height_reg  = FH_W'(MAX_HEIGHT);
        left_pix    = '0;
        col_pos     = 0;
        row_pos     = 0;
        error_count = 0;
        stall_left  = 0;
        no_idle     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_directed_extremes();
        test_register_limits();
        test_random_settings();
        test_steady_stream();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
